/* hdl/sfd_pkg.sv */
package sfd_pkg;

  // frame layout
  localparam logic [7:0]  SYNC_BYTE     = 8'h0F;
  localparam int          STORED_BYTES  = 24;
  localparam int          FAILSAFE_BYTE = 22;
  localparam int          FAILSAFE_BIT  = 3;
  localparam int          RAW_W         = 11;
  localparam logic [10:0] RAW_MID       = 11'd992;
  localparam logic [11:0] PULSE_OFFSET  = 12'd880;
  localparam int          MAX_RESULTS   = 8;

  // default channel count
  localparam int NUM_CHANNELS_DEF = 8;

  // configuration port
  localparam int          CFG_IDX_W       = 2;
  localparam int          CFG_DATA_W      = 24;
  localparam logic [1:0]  CFG_GAP_LIMIT   = 2'd0;
  localparam logic [1:0]  CFG_FAILSAFE_EN = 2'd1;
  localparam logic [1:0]  CFG_CHANNEL_MAP = 2'd2;
  localparam logic [15:0] GAP_LIMIT_RST   = 16'd2500;
  localparam logic [23:0] CHANNEL_MAP_RST = 24'hFAC688;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] arrival_us;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  channel_index;
    logic [11:0] pulse_us;
    logic        failsafe_seen;
    logic        frame_accepted;
    logic        last;
  } out_res_t;

  typedef struct packed {
    logic [15:0] gap_limit_us;
    logic        failsafe_enable;
    logic [23:0] channel_map;
  } cfg_t;

  // queue handshake between front and back
  typedef struct packed {
    logic push;
    logic full;
    logic pop;
    logic valid;
  } queue_ctl_t;

endpackage

/* hdl/sfd_queue.sv */
module sfd_queue #(
  parameter int WIDTH = 90
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  logic [1:0][WIDTH-1:0] mem_q;
  logic                  wr_ptr_q, wr_ptr_d;
  logic                  rd_ptr_q, rd_ptr_d;
  logic [1:0]            count_q, count_d;

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* hdl/sfd_front.sv */
module sfd_front #(
  parameter int NUM_CHANNELS = sfd_pkg::NUM_CHANNELS_DEF,
  localparam int QW = NUM_CHANNELS * sfd_pkg::RAW_W + 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfd_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sfd_pkg::in_req_t   in_req_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output logic [QW-1:0]      q_wdata_o
);

  localparam int ByteW = sfd_pkg::STORED_BYTES * 8;

  logic [4:0]  pos_q, pos_d, pos_eff;
  logic [31:0] last_arrival_q;
  logic [31:0] gap;
  logic        accept;
  logic        complete;
  logic        fs;
  logic        frame_ok;

  logic [sfd_pkg::STORED_BYTES-1:0][7:0] bytes_q;
  logic [sfd_pkg::STORED_BYTES-1:0][7:0] bytes_all;
  logic [ByteW-1:0]                      bytes_flat;
  logic [NUM_CHANNELS-1:0][10:0]         chan_q;
  logic [NUM_CHANNELS-1:0][10:0]         chan_new;
  logic [NUM_CHANNELS-1:0][10:0]         chan_out;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // gap check restarts framing
  assign gap     = in_req_i.arrival_us - last_arrival_q;
  assign pos_eff = (gap > {16'd0, cfg_i.gap_limit_us}) ? 5'd0 : pos_q;

  // frame position sequencing
  always_comb begin
    complete = 1'b0;
    if (pos_eff == 5'd0) begin
      pos_d = (in_req_i.rx_byte == sfd_pkg::SYNC_BYTE) ? 5'd1 : 5'd0;
    end else if (pos_eff < 5'(sfd_pkg::STORED_BYTES)) begin
      pos_d = pos_eff + 5'd1;
    end else begin
      pos_d    = 5'd0;
      complete = 1'b1;
    end
  end

  // stored bytes with the closing byte merged in
  always_comb begin
    bytes_all = bytes_q;
    bytes_all[sfd_pkg::STORED_BYTES-1] = in_req_i.rx_byte;
  end
  assign bytes_flat = bytes_all;

  // channel unpack, little-endian 11-bit fields
  always_comb begin
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      chan_new[k] = bytes_flat[k*sfd_pkg::RAW_W +: sfd_pkg::RAW_W];
    end
  end

  assign fs       = bytes_q[sfd_pkg::FAILSAFE_BYTE][sfd_pkg::FAILSAFE_BIT];
  assign frame_ok = !(cfg_i.failsafe_enable && fs);
  assign chan_out = frame_ok ? chan_new : chan_q;

  assign q_push_o  = accept && complete;
  assign q_wdata_o = {chan_out, fs, frame_ok};

  // control state and channel store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q          <= 5'd0;
      last_arrival_q <= 32'd0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        chan_q[k] <= sfd_pkg::RAW_MID;
      end
    end else if (accept) begin
      pos_q          <= pos_d;
      last_arrival_q <= in_req_i.arrival_us;
      if (complete && frame_ok) begin
        chan_q <= chan_new;
      end
    end
  end

  // frame byte capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < sfd_pkg::STORED_BYTES; i++) begin
        if (pos_eff == 5'(i + 1)) begin
          bytes_q[i] <= in_req_i.rx_byte;
        end
      end
    end
  end

endmodule

/* hdl/sfd_back.sv */
module sfd_back #(
  parameter int NUM_CHANNELS = sfd_pkg::NUM_CHANNELS_DEF,
  localparam int QW = NUM_CHANNELS * sfd_pkg::RAW_W + 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfd_pkg::cfg_t      cfg_i,
  input  logic               q_valid_i,
  input  logic [QW-1:0]      q_rdata_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sfd_pkg::out_res_t  out_res_o
);

  localparam int NumOut = (NUM_CHANNELS < sfd_pkg::MAX_RESULTS) ?
                          NUM_CHANNELS : sfd_pkg::MAX_RESULTS;
  localparam int SrcW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic                          busy_q;
  logic [2:0]                    cnt_q;
  logic [QW-1:0]                 entry_q;
  logic                          out_valid_q;
  sfd_pkg::out_res_t             out_q;
  sfd_pkg::out_res_t             res;
  logic [NUM_CHANNELS-1:0][10:0] raw_set;
  logic [4:0]                    src_w;
  logic [SrcW-1:0]               src_sel;
  logic [10:0]                   raw;
  logic [13:0]                   prod;
  logic                          advance;
  logic                          emit;
  logic                          is_last;

  assign raw_set = entry_q[QW-1:2];
  assign is_last = (cnt_q == 3'(NumOut - 1));
  assign advance = !out_valid_q || !out_stall_i;
  assign emit    = busy_q && advance;
  assign q_pop_o = q_valid_i && (!busy_q || (emit && is_last));

  // source lookup with clamp to the highest channel
  always_comb begin
    src_w = {2'b00, cfg_i.channel_map[cnt_q*3 +: 3]};
    if (src_w >= 5'(NUM_CHANNELS)) begin
      src_w = 5'(NUM_CHANNELS - 1);
    end
  end
  assign src_sel = src_w[SrcW-1:0];
  assign raw     = raw_set[src_sel];

  // pulse scaling, floor(5*raw/8) + offset
  assign prod = {1'b0, raw, 2'b00} + {3'b000, raw};

  always_comb begin
    res.channel_index  = cnt_q;
    res.pulse_us       = {1'b0, prod[13:3]} + sfd_pkg::PULSE_OFFSET;
    res.failsafe_seen  = entry_q[1];
    res.frame_accepted = entry_q[0];
    res.last           = is_last;
  end

  // result sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd0;
      end else if (emit) begin
        if (is_last) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 3'd1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      entry_q <= q_rdata_i;
    end
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

/* hdl/sbus_frame_decoder.sv */
// channel  fields                                  valid        stall
// in       rx_byte, arrival_us                     in_valid_i   in_stall_o
// out      channel_index, pulse_us, failsafe_seen,
//          frame_accepted, last                    out_valid_o  out_stall_i
// cfg      cfg_idx_i, cfg_wdata_i                  cfg_we_i     -
//
// unless stalled, one byte goes in and one result out per cycle; a closing byte hands
// the frame to a two-entry queue; the back emits min(NUM_CHANNELS, 8) results; an
// idle back loads a frame first, a queued one with the last result of the one before
// in_stall_o rises only while the queue holds two frames not yet started by the back
// the output register is freed in the same cycle its result is taken
// reset sets the channel store to mid value and framing to the sync search
module sbus_frame_decoder #(
  parameter int NUM_CHANNELS = sfd_pkg::NUM_CHANNELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sfd_pkg::in_req_t               in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sfd_pkg::out_res_t              out_res_o
);

  localparam int QW = NUM_CHANNELS * sfd_pkg::RAW_W + 2;

  sfd_pkg::cfg_t       cfg_q;
  sfd_pkg::queue_ctl_t qctl;
  logic [QW-1:0]       q_wdata;
  logic [QW-1:0]       q_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_limit_us    <= sfd_pkg::GAP_LIMIT_RST;
      cfg_q.failsafe_enable <= 1'b0;
      cfg_q.channel_map     <= sfd_pkg::CHANNEL_MAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfd_pkg::CFG_GAP_LIMIT:   cfg_q.gap_limit_us    <= cfg_wdata_i[15:0];
        sfd_pkg::CFG_FAILSAFE_EN: cfg_q.failsafe_enable <= cfg_wdata_i[0];
        sfd_pkg::CFG_CHANNEL_MAP: cfg_q.channel_map     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sfd_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .q_full_i   (qctl.full),
    .q_push_o   (qctl.push),
    .q_wdata_o  (q_wdata)
  );

  sfd_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (qctl.push),
    .wdata_i (q_wdata),
    .full_o  (qctl.full),
    .pop_i   (qctl.pop),
    .valid_o (qctl.valid),
    .rdata_o (q_rdata)
  );

  sfd_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (qctl.valid),
    .q_rdata_i   (q_rdata),
    .q_pop_o     (qctl.pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule

/* hdl/sfd_checker.sv */
module sfd_checker #(
  parameter int NUM_CHANNELS = sfd_pkg::NUM_CHANNELS_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_stall_i,
  input sfd_pkg::out_res_t out_res_i
);

  localparam int NumOut = (NUM_CHANNELS < sfd_pkg::MAX_RESULTS) ?
                          NUM_CHANNELS : sfd_pkg::MAX_RESULTS;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_res_i))
    else $error("stalled result changed");

  // results of one frame follow without a gap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_stall_i && !out_res_i.last |=> out_valid_i)
    else $error("gap inside a frame's results");

  // last result carries the final channel number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_res_i.last |-> out_res_i.channel_index == 3'(NumOut - 1))
    else $error("last flag on wrong channel");

  // a rejected frame always had its failsafe bit set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_res_i.frame_accepted |-> out_res_i.failsafe_seen)
    else $error("frame rejected without failsafe");

  // pulse stays in the scaled range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_res_i.pulse_us >= 12'd880 && out_res_i.pulse_us <= 12'd2159)
    else $error("pulse out of range");

endmodule

bind sbus_frame_decoder sfd_checker #(
  .NUM_CHANNELS(NUM_CHANNELS)
) u_sfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_i   (out_res_o)
);

/* dv/sbus_frame_decoder_tb.sv */
`timescale 1ns / 1ps

module sbus_frame_decoder_tb;
  import sfd_pkg::*;

  localparam int NCH          = NUM_CHANNELS_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_PCT     = 26;
  localparam int REPORT_MAX   = 10;
  localparam int MAX_INNER_DT = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES, FILL_SYNCS} fill_e;

  // dut ports; the inputs are known from time zero
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = CFG_GAP_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  in_req_t               in_req_i    = '0;
  logic                  out_stall_i = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  out_res_t              out_res_o;

  // decoder shadow: registers, framing and channel store
  logic [15:0] gap_lim_q;
  logic        fs_en_q;
  logic [23:0] chan_map_q;
  logic [4:0]  pos_q;
  logic [31:0] last_t_q;
  logic [7:0]  fbytes [STORED_BYTES];
  logic [10:0] raw_q [NCH];
  out_res_t    pending_pulses [$];

  // request feed and side control
  in_req_t     byte_feed [$];
  logic [31:0] now_us = '0;
  int          send_idle_pct = IDLE_PCT;
  int          recv_idle_pct = IDLE_PCT;
  int          hold_asked = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  bit          in_taken = 1'b0;

  // bookkeeping
  int bad_count = 0;
  int results_seen = 0;
  int frames_done = 0;
  int frames_rej = 0;
  int in_stall_cycles = 0;
  int cycle_count = 0;

  sbus_frame_decoder #(
    .NUM_CHANNELS(NCH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

  always #5 clk_i = ~clk_i;

  // advance framing by one byte, queue the channel results of a closed frame
  task automatic decode_byte(in_req_t r);
    logic [31:0] dt;
    logic [8*STORED_BYTES-1:0] flat;
    logic fs;
    logic acc;
    int src;
    int n;
    int v;
    out_res_t want;
    dt = r.arrival_us - last_t_q;
    if (dt > {16'b0, gap_lim_q}) pos_q = '0;
    last_t_q = r.arrival_us;
    if (!(pos_q == 0 && r.rx_byte != SYNC_BYTE)) begin
      if (pos_q != 0) fbytes[pos_q - 5'd1] = r.rx_byte;
      if (pos_q < STORED_BYTES) begin
        pos_q = pos_q + 5'd1;
      end else begin
        pos_q = '0;
        fs = fbytes[FAILSAFE_BYTE][FAILSAFE_BIT];
        acc = !(fs_en_q && fs);
        frames_done++;
        if (!acc) frames_rej++;
        // little-endian 11-bit unpack from the stored bytes
        if (acc) begin
          for (int k = 0; k < STORED_BYTES; k++) flat[8*k +: 8] = fbytes[k];
          for (int k = 0; k < NCH; k++) raw_q[k] = flat[RAW_W*k +: RAW_W];
        end
        n = (NCH < MAX_RESULTS) ? NCH : MAX_RESULTS;
        for (int i = 0; i < n; i++) begin
          src = int'(chan_map_q[3*i +: 3]);
          if (src >= NCH) src = NCH - 1;
          v = (int'(raw_q[src]) * 5) / 8 + int'(PULSE_OFFSET);
          want.channel_index  = 3'(i);
          want.pulse_us       = 12'(v);
          want.failsafe_seen  = fs;
          want.frame_accepted = acc;
          want.last           = (i == n - 1);
          pending_pulses.push_back(want);
        end
      end
    end
  endtask

  task automatic note_bad(string what);
    bad_count++;
    if (bad_count <= REPORT_MAX) $display("[%0t] %s", $time, what);
  endtask

  // compare one result against the oldest queued channel result
  task automatic check_pulse(out_res_t got);
    out_res_t want;
    if (pending_pulses.size() == 0) begin
      note_bad($sformatf("unexpected result ch %0d pulse %0d fs %b acc %b last %b",
                         got.channel_index, got.pulse_us, got.failsafe_seen,
                         got.frame_accepted, got.last));
    end else begin
      want = pending_pulses.pop_front();
      results_seen++;
      if (got.channel_index !== want.channel_index || got.pulse_us !== want.pulse_us ||
          got.failsafe_seen !== want.failsafe_seen ||
          got.frame_accepted !== want.frame_accepted || got.last !== want.last)
        note_bad($sformatf({"result mismatch: got ch %0d pulse %0d fs %b acc %b last %b,",
                            " expected ch %0d pulse %0d fs %b acc %b last %b"},
                           got.channel_index, got.pulse_us, got.failsafe_seen,
                           got.frame_accepted, got.last, want.channel_index,
                           want.pulse_us, want.failsafe_seen, want.frame_accepted,
                           want.last));
    end
  endtask

  // monitor: accepted requests feed the shadow, accepted results are checked
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) in_stall_cycles++;
      if (in_taken) decode_byte(in_req_i);
      if (out_valid_o && !out_stall_i) check_pulse(out_res_o);
    end
  end

  // driver: hold a stalled request, otherwise offer the next one or idle
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_req_i   <= byte_feed.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold when one is asked for
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped at cycle limit %0d, %0d results still expected",
               CYCLE_LIMIT, pending_pulses.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // spacing inside a frame: never above the gap limit
  function automatic logic [31:0] inner_dt();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return {16'b0, gap_lim_q};
    else if (pick == 1) return 32'd0;
    else return $urandom_range((gap_lim_q < MAX_INNER_DT) ? gap_lim_q : MAX_INNER_DT);
  endfunction

  // spacing before a sync: mostly above the limit, sometimes just over, rarely anything
  function automatic logic [31:0] restart_dt();
    int pick;
    pick = $urandom_range(9);
    if (pick < 2) return {16'b0, gap_lim_q} + 32'd1;
    else if (pick == 2) return $urandom;
    else return {16'b0, gap_lim_q} + 32'd1 + $urandom_range(20000);
  endfunction

  task automatic push_byte(logic [7:0] b, logic [31:0] dt);
    in_req_t r;
    now_us = now_us + dt;
    r.rx_byte = b;
    r.arrival_us = now_us;
    byte_feed.push_back(r);
  endtask

  // sync byte followed by len stored bytes
  task automatic push_frame(fill_e fill, int len, logic [31:0] sync_dt);
    logic [7:0] b;
    push_byte(SYNC_BYTE, sync_dt);
    for (int k = 0; k < len; k++) begin
      case (fill)
        FILL_ZEROS: b = 8'h00;
        FILL_ONES:  b = 8'hFF;
        FILL_SYNCS: b = ($urandom_range(2) == 0) ? SYNC_BYTE : 8'($urandom);
        default:    b = 8'($urandom);
      endcase
      push_byte(b, inner_dt());
    end
  endtask

  // mostly whole frames, some cut short, some line noise
  task automatic random_traffic(int budget);
    int used;
    int pick;
    int len;
    fill_e fill;
    used = 0;
    while (used < budget) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        pick = $urandom_range(99);
        fill = (pick < 70) ? FILL_RANDOM : (pick < 80) ? FILL_ZEROS :
               (pick < 90) ? FILL_ONES : FILL_SYNCS;
        push_frame(fill, STORED_BYTES, restart_dt());
        used += STORED_BYTES + 1;
      end else if (pick < 88) begin
        len = $urandom_range(STORED_BYTES - 1, 1);
        push_frame(FILL_RANDOM, len, restart_dt());
        used += len + 1;
      end else begin
        // noise, mostly dropped during sync search
        repeat ($urandom_range(4, 1)) push_byte(8'($urandom), $urandom);
      end
    end
  endtask

  // wait for every request taken and every result back, then let the block go quiet
  task automatic settle();
    while (byte_feed.size() != 0 || in_valid_i || pending_pulses.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_GAP_LIMIT:   gap_lim_q = val[15:0];
      CFG_FAILSAFE_EN: fs_en_q = val[0];
      CFG_CHANNEL_MAP: chan_map_q = val[23:0];
      default: ;
    endcase
  endtask

  // unused upper data bits carry random junk
  task automatic set_regs(logic [15:0] gap, logic fs_en, logic [23:0] map);
    write_reg(CFG_GAP_LIMIT, {8'($urandom), gap});
    write_reg(CFG_FAILSAFE_EN, {23'($urandom), fs_en});
    write_reg(CFG_CHANNEL_MAP, map);
  endtask

  initial begin
    logic [15:0] gap;
    gap_lim_q  = GAP_LIMIT_RST;
    fs_en_q    = 1'b0;
    chan_map_q = CHANNEL_MAP_RST;
    pos_q      = '0;
    last_t_q   = '0;
    for (int k = 0; k < NCH; k++) raw_q[k] = RAW_MID;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: ignored bytes at both ends of the ranges, then a full-scale
    // frame whose timestamps wrap through zero
    push_byte(8'h00, 32'd0);
    push_byte(8'hFF, 32'hFFFF_FFFF);
    push_frame(FILL_ONES, STORED_BYTES, 32'hFFFF_FF00);
    random_traffic(30);
    settle();

    // widest gap, failsafe rejection, every output from source 0
    set_regs(16'hFFFF, 1'b1, 24'h000000);
    push_frame(FILL_ONES, STORED_BYTES, restart_dt());
    random_traffic(30);
    settle();

    // zero gap: only equal timestamps hold a frame together
    set_regs(16'h0000, 1'b0, 24'hFFFFFF);
    random_traffic(30);
    settle();

    // back-to-back frames against a long output hold, no idling
    set_regs(16'($urandom), 1'b1, 24'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) push_frame(FILL_RANDOM, STORED_BYTES, restart_dt());
    hold_asked++;
    settle();
    send_idle_pct = IDLE_PCT;
    recv_idle_pct = IDLE_PCT;

    // random settings, with a write to the unused index on the way
    for (int p = 0; p < 3; p++) begin
      gap = ($urandom_range(3) == 0) ? 16'($urandom_range(50)) : 16'($urandom);
      set_regs(gap, 1'($urandom_range(1)), 24'($urandom));
      if (p == 1) write_reg(CFG_UNUSED, 24'($urandom));
      random_traffic(35);
      settle();
    end

    if (pending_pulses.size() != 0)
      note_bad($sformatf("%0d results never arrived", pending_pulses.size()));
    $display("covered %0d frames (%0d rejected on failsafe), %0d results compared",
             frames_done, frames_rej, results_seen);
    $display("input held off for %0d cycles under output backpressure", in_stall_cycles);
    if (bad_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
